>>> src/bc40_pkg.sv
// shared types, constants and symbol helpers for the base-40 callsign codec
package bc40_pkg;

    localparam int NCHARS     = 9;
    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 48;
    localparam int DIGIT_W    = 6;
    localparam int SHIFT_BITS = 3;                     // bits folded in per cell, 8 divides 40
    localparam int NCELLS     = CODE_W / SHIFT_BITS;
    localparam int ENC_CNT_W  = 4;
    localparam int SIDE_W     = NCHARS * CHAR_W;
    localparam int TDATA_W    = SIDE_W + CODE_W;
    localparam int TUSER_IN_W  = 1;
    localparam int TUSER_OUT_W = 2;
    localparam int BCAST_LEN  = 4;

    localparam logic [CODE_W-1:0] EXT_OFFSET = 48'hEE6B28000000;
    localparam logic [CODE_W-1:0] EXT_FLOOR  = 48'hEE6B27FFFFFF;
    localparam logic [CODE_W-1:0] CODE_LIMIT = 48'hF46108FFFFFF;
    localparam logic [CODE_W-1:0] CODE_BCAST = 48'hFFFFFFFFFFFF;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

    // "@ALL" and "@INVALID", character 0 in the lowest byte, zero padded
    localparam logic [SIDE_W-1:0] BCAST_TXT = 72'h00_0000_0000_4C4C_4140;
    localparam logic [SIDE_W-1:0] INVAL_TXT = 72'h00_4449_4C41_564E_4940;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } bc_op_t;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_BCAST   = 2'd1,
        ST_INVALID = 2'd2
    } bc_status_t;

    // one item as it travels down the cell row
    typedef struct packed {
        bc_op_t                          op;
        logic                            ext;
        bc_status_t                      status;
        logic [SIDE_W-1:0]               side;      // encode text or decode code echo
        logic [ENC_CNT_W-1:0]            enc_left;  // encode digits still to fold in
        logic [CODE_W-1:0]               acc;
        logic [NCHARS-1:0][DIGIT_W-1:0]  dig;
    } bc_lane_t;

    // alphabet index of a character, anything outside the alphabet maps to space
    function automatic logic [DIGIT_W-1:0] sym_index(input logic [CHAR_W-1:0] ch);
        logic [DIGIT_W-1:0] idx;
        idx = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            idx = DIGIT_W'(ch - 8'h40);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            idx = DIGIT_W'(ch - 8'h15);
        end else if (ch == 8'h2D) begin
            idx = 6'd37;
        end else if (ch == 8'h2F) begin
            idx = 6'd38;
        end else if (ch == 8'h2E) begin
            idx = 6'd39;
        end
        return idx;
    endfunction

    // character of an alphabet index
    function automatic logic [CHAR_W-1:0] sym_char(input logic [DIGIT_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        ch = CH_NUL;
        if (idx == '0) begin
            ch = CH_SPACE;
        end else if (idx <= 6'd26) begin
            ch = 8'h40 + CHAR_W'(idx);
        end else if (idx <= 6'd36) begin
            ch = 8'h15 + CHAR_W'(idx);
        end else if (idx == 6'd37) begin
            ch = 8'h2D;
        end else if (idx == 6'd38) begin
            ch = 8'h2F;
        end else if (idx == 6'd39) begin
            ch = 8'h2E;
        end
        return ch;
    endfunction

endpackage

>>> src/base40_callsign_codec.sv
// top level of the base-40 callsign address codec
//
// usage
//   input stream  s_*: one transaction is one operation. s_tuser selects it
//     (0 encode nine characters, 1 decode a 48-bit address); s_tdata carries
//     the nine characters and the address to decode.
//   output stream m_*: one transaction per input transaction, in order.
//     m_tdata carries nine result characters and the 48-bit address,
//     m_tuser the status (normal, broadcast, invalid).
//   path: the accepting edge loads the entry stage (character mapping,
//     range compares, offset subtract), then the item passes sixteen
//     conversion cells of three address bits each and then the output
//     register that rebuilds the characters; m_tvalid rises as it lands.
//   throughput: one transaction per cycle; every stage is a register with
//     its own valid, so bubbles collapse and input keeps flowing while a
//     result waits in the output register, as long as a stage ahead is free.
//   stall: when m_tready is low the output holds; stages fill up behind it
//     and s_tready drops only once every stage is occupied.
//   reset: aresetn low empties all stages; nothing else needs clearing.
module base40_callsign_codec (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // chars 0..8 (8 bits each, char 0 lowest), then code_in (48 bits)
    input  logic [bc40_pkg::TDATA_W-1:0]        s_tdata,
    // opcode (1 bit)
    input  logic [bc40_pkg::TUSER_IN_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out chars 0..8 (8 bits each, char 0 lowest), then code_out (48 bits)
    output logic [bc40_pkg::TDATA_W-1:0]        m_tdata,
    // status (2 bits)
    output logic [bc40_pkg::TUSER_OUT_W-1:0]    m_tuser
);
    import bc40_pkg::*;

    // entry stage signals
    logic [NCHARS-1:0][CHAR_W-1:0]   src;
    logic [NCHARS-1:0][DIGIT_W-1:0]  pos_eff;
    logic [NCHARS-1:0][DIGIT_W-1:0]  enc_dig;
    logic [NCHARS-1:0][CHAR_W-1:0]   res;
    logic [NCHARS-1:0][CHAR_W-1:0]   enc_txt;
    logic [NCHARS-1:0]               present;
    logic [NCHARS-1:0]               nonspace;
    logic [NCHARS-1:0]               keep;
    logic                            enc_ext;
    logic                            enc_bcast;
    logic [CODE_W-1:0]               code_in;
    logic                            dec_bcast;
    logic                            dec_inval;
    logic                            dec_ext;
    logic [CODE_W-1:0]               dec_work;

    logic      front_valid_reg;
    bc_lane_t  front_lane_reg;
    bc_lane_t  front_lane_next;
    logic      front_ready;

    // cell row
    logic      cell_valid [NCELLS+1];
    logic      cell_ready [NCELLS+1];
    bc_lane_t  cell_lane  [NCELLS+1];

    // output stage signals
    bc_lane_t                        last;
    logic [NCHARS-1:0]               sig;
    logic [NCHARS-1:0][CHAR_W-1:0]   dchar;
    logic [NCHARS-1:0][CHAR_W-1:0]   out_txt;
    logic [CODE_W-1:0]               out_code;
    logic                            out_ready;

    logic                            m_valid_reg;
    logic [TDATA_W-1:0]              m_data_reg;
    logic [TDATA_W-1:0]              m_data_next;
    logic [TUSER_OUT_W-1:0]          m_user_reg;
    logic [TUSER_OUT_W-1:0]          m_user_next;

    // ---------------------------------------------------------------
    // entry stage: map characters, prepare digits or working value
    // ---------------------------------------------------------------
    assign code_in = s_tdata[TDATA_W-1 -: CODE_W];

    always_comb begin
        for (int i = 0; i < NCHARS; i++) begin
            src[i] = s_tdata[i*CHAR_W +: CHAR_W];
        end
        // string ends at the first zero character
        present[0] = (src[0] != CH_NUL);
        for (int i = 1; i < NCHARS; i++) begin
            present[i] = present[i-1] && (src[i] != CH_NUL);
        end
        enc_ext   = present[0] && (src[0] == CH_HASH);
        // exactly "@ALL" followed by the terminating zero
        enc_bcast = (s_tdata[(BCAST_LEN+1)*CHAR_W-1:0] == BCAST_TXT[(BCAST_LEN+1)*CHAR_W-1:0]);

        for (int i = 0; i < NCHARS; i++) begin
            pos_eff[i]  = present[i] ? sym_index(src[i]) : '0;
            res[i]      = present[i] ? sym_char(pos_eff[i]) : CH_NUL;
            nonspace[i] = present[i] && (pos_eff[i] != '0);
        end
        if (enc_ext) begin
            res[0]      = CH_HASH;
            nonspace[0] = 1'b1;
        end

        // trailing spaces are cleared: keep a position if it or anything after it is nonspace
        keep[NCHARS-1] = nonspace[NCHARS-1];
        for (int i = NCHARS - 2; i >= 0; i--) begin
            keep[i] = keep[i+1] || nonspace[i];
        end
        for (int i = 0; i < NCHARS; i++) begin
            enc_txt[i] = keep[i] ? res[i] : CH_NUL;
        end

        // extended: the hash is not packed, the rest moves down one digit
        for (int i = 0; i < NCHARS - 1; i++) begin
            enc_dig[i] = enc_ext ? pos_eff[i+1] : pos_eff[i];
        end
        enc_dig[NCHARS-1] = enc_ext ? '0 : pos_eff[NCHARS-1];
    end

    assign dec_bcast = (code_in == CODE_BCAST);
    assign dec_inval = !dec_bcast && (code_in > CODE_LIMIT);
    assign dec_ext   = !dec_bcast && !dec_inval && (code_in > EXT_FLOOR);
    assign dec_work  = code_in - EXT_OFFSET;

    always_comb begin
        front_lane_next = '0;
        front_lane_next.op = bc_op_t'(s_tuser[0]);
        if (bc_op_t'(s_tuser[0]) == OP_DECODE) begin
            front_lane_next.ext    = dec_ext;
            front_lane_next.status = dec_bcast ? ST_BCAST : (dec_inval ? ST_INVALID : ST_NORMAL);
            front_lane_next.side   = {{(SIDE_W-CODE_W){1'b0}}, code_in};
            front_lane_next.acc    = dec_ext ? dec_work : code_in;
        end else begin
            front_lane_next.ext      = enc_ext;
            front_lane_next.status   = enc_bcast ? ST_BCAST : ST_NORMAL;
            front_lane_next.side     = enc_bcast ? BCAST_TXT : enc_txt;
            front_lane_next.enc_left = ENC_CNT_W'(NCHARS);
            // a leading one shifted up nine digits lands on the extended offset
            front_lane_next.acc      = CODE_W'(enc_ext);
            front_lane_next.dig      = enc_dig;
        end
    end

    assign front_ready = !front_valid_reg || cell_ready[0];
    assign s_tready    = front_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (front_ready) begin
            front_valid_reg <= s_tvalid;
        end
        if (front_ready && s_tvalid) begin
            front_lane_reg <= front_lane_next;
        end
    end

    // ---------------------------------------------------------------
    // conversion row: each cell takes three address bits (decode) or
    // one base-40 digit (encode, first nine cells)
    // ---------------------------------------------------------------
    assign cell_valid[0]      = front_valid_reg;
    assign cell_lane[0]       = front_lane_reg;
    assign cell_ready[NCELLS] = out_ready;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        bc40_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_lane   (cell_lane[k]),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_lane  (cell_lane[k+1])
        );
    end

    // ---------------------------------------------------------------
    // output stage: digits back to characters, special cases
    // ---------------------------------------------------------------
    assign last = cell_lane[NCELLS];

    always_comb begin
        // a digit shows only up to the most significant nonzero one
        sig[NCHARS-1] = (last.dig[NCHARS-1] != '0);
        for (int i = NCHARS - 2; i >= 0; i--) begin
            sig[i] = sig[i+1] || (last.dig[i] != '0);
        end
        for (int i = 0; i < NCHARS; i++) begin
            dchar[i] = sig[i] ? sym_char(last.dig[i]) : CH_NUL;
        end

        out_txt  = last.side;
        out_code = last.acc;
        if (last.op == OP_ENCODE) begin
            if (last.status == ST_BCAST) begin
                out_code = CODE_BCAST;
            end
        end else begin
            out_code = last.side[CODE_W-1:0];
            unique case (last.status)
                ST_BCAST:   out_txt = BCAST_TXT;
                ST_INVALID: out_txt = INVAL_TXT;
                default: begin
                    if (last.ext) begin
                        out_txt[0] = CH_HASH;
                        for (int i = 0; i < NCHARS - 1; i++) begin
                            out_txt[i+1] = dchar[i];
                        end
                    end else begin
                        out_txt = dchar;
                    end
                end
            endcase
        end
        m_data_next = {out_code, out_txt};
        m_user_next = last.status;
    end

    assign out_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= cell_valid[NCELLS];
        end
        if (out_ready && cell_valid[NCELLS]) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // broadcast status always comes with the all-ones address
    a_bcast_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_BCAST) |-> (m_tdata[TDATA_W-1 -: CODE_W] == CODE_BCAST))
        else $error("broadcast status without all-ones address");

    // invalid status only for addresses above the limit
    a_inval_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_INVALID) |-> (m_tdata[TDATA_W-1 -: CODE_W] > CODE_LIMIT))
        else $error("invalid status on an address inside the range");

    // a normal result never carries an address beyond the extended range
    a_norm_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_NORMAL) |-> (m_tdata[TDATA_W-1 -: CODE_W] <= CODE_LIMIT))
        else $error("normal status on an out of range address");

    // the first stage takes an accepted transaction
    a_entry_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> front_valid_reg)
        else $error("accepted transaction lost at the entry stage");

endmodule

>>> src/bc40_cell.sv
// one cell of the conversion row: folds three code bits into base-40 digits or one digit into the code
module bc40_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bc40_pkg::bc_lane_t  in_lane,
    output logic                out_valid,
    input  logic                out_ready,
    output bc40_pkg::bc_lane_t  out_lane
);
    import bc40_pkg::*;

    logic      valid_reg;
    bc_lane_t  lane_reg;
    bc_lane_t  lane_next;

    logic [NCHARS-1:0][2:0] quo;
    logic [NCHARS-1:0][2:0] rem;
    logic [9:0]             prod;
    logic [DIGIT_W-1:0]     rem_full;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

    always_comb begin
        lane_next = in_lane;
        prod      = '0;
        rem_full  = '0;
        // digit / 5 by reciprocal, exact for digits below 40
        for (int i = 0; i < NCHARS; i++) begin
            prod     = 10'(in_lane.dig[i]) * 10'd13;
            quo[i]   = prod[8:6];
            rem_full = in_lane.dig[i] - DIGIT_W'(quo[i]) * 6'd5;
            rem[i]   = rem_full[2:0];
        end
        if (in_lane.op == OP_DECODE) begin
            // digits = digits * 8 + top bits; carry out of a digit is digit / 5
            lane_next.acc = {in_lane.acc[CODE_W-SHIFT_BITS-1:0], {SHIFT_BITS{1'b0}}};
            lane_next.dig[0] = {rem[0], in_lane.acc[CODE_W-1 -: SHIFT_BITS]};
            for (int i = 1; i < NCHARS; i++) begin
                lane_next.dig[i] = {rem[i], quo[i-1]};
            end
        end else if (in_lane.enc_left != '0) begin
            // horner step: acc * 40 + most significant pending digit
            lane_next.acc = {in_lane.acc[CODE_W-6:0], 5'b0}
                          + {in_lane.acc[CODE_W-4:0], 3'b0}
                          + CODE_W'(in_lane.dig[NCHARS-1]);
            for (int i = NCHARS - 1; i > 0; i--) begin
                lane_next.dig[i] = in_lane.dig[i-1];
            end
            lane_next.dig[0]  = '0;
            lane_next.enc_left = in_lane.enc_left - ENC_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            lane_reg <= lane_next;
        end
    end

endmodule

>>> tb/bc40_result_checker.sv
// result checker for the base-40 callsign codec: predicts each result and compares it
`timescale 1ns / 1ps

module bc40_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [bc40_pkg::TDATA_W-1:0]      s_tdata,
    input  logic [bc40_pkg::TUSER_IN_W-1:0]   s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bc40_pkg::TDATA_W-1:0]      m_tdata,
    input  logic [bc40_pkg::TUSER_OUT_W-1:0]  m_tuser,
    output int                                fail_count,
    output int                                pending_results,
    output int                                n_encode,
    output int                                n_decode,
    output int                                n_bcast,
    output int                                n_extended,
    output int                                n_invalid,
    output int                                n_held
);
    import bc40_pkg::*;

    typedef logic [NCHARS-1:0][CHAR_W-1:0] char_row_t;

    typedef struct packed {
        char_row_t          chars;
        logic [CODE_W-1:0]  code;
        bc_status_t         status;
    } codec_result_t;

    localparam string ALPHABET    = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/.";
    localparam int    RADIX       = 40;
    localparam int    MAX_REPORTS = 40;

    codec_result_t awaited_results[$];
    int errs     = 0;
    int enc_cnt  = 0;
    int dec_cnt  = 0;
    int bc_cnt   = 0;
    int ext_cnt  = 0;
    int inv_cnt  = 0;
    int held_cnt = 0;

    // alphabet position of a character, -1 when outside
    function automatic int alpha_pos(logic [CHAR_W-1:0] ch);
        int k;
        for (k = 0; k < RADIX; k++) begin
            if (ALPHABET[k] == ch) return k;
        end
        return -1;
    endfunction

    function automatic codec_result_t predict_codec(bc_op_t op, char_row_t src,
                                                    logic [CODE_W-1:0] code_in);
        codec_result_t r;
        logic [63:0]   acc;
        int            n;
        int            k;
        int            i;
        int            pos;
        bit            ext;
        r.chars  = '0;
        r.code   = '0;
        r.status = ST_NORMAL;
        acc      = '0;
        ext      = 1'b0;
        n        = 0;
        if (op == OP_ENCODE) begin
            while (n < NCHARS && src[n] != CH_NUL) n++;
            if (n == BCAST_LEN && src[BCAST_LEN-1:0] == BCAST_TXT[BCAST_LEN*CHAR_W-1:0]) begin
                r.chars  = BCAST_TXT;
                r.code   = CODE_BCAST;
                r.status = ST_BCAST;
                return r;
            end
            // last character first so the first one ends least significant
            for (k = n; k > 0; k--) begin
                i   = k - 1;
                pos = alpha_pos(src[i]);
                if (pos < 0) begin
                    if (i == 0 && src[i] == CH_HASH) begin
                        ext        = 1'b1;
                        r.chars[0] = CH_HASH;
                        break;
                    end
                    pos = 0;
                end
                r.chars[i] = ALPHABET[pos];
                acc        = acc * RADIX + 64'(pos);
            end
            if (ext) acc = acc + 64'(EXT_OFFSET);
            while (n > 0 && r.chars[n-1] == CH_SPACE) begin
                r.chars[n-1] = CH_NUL;
                n--;
            end
            r.code = acc[CODE_W-1:0];
        end else begin
            r.code = code_in;
            if (code_in == CODE_BCAST) begin
                r.chars  = BCAST_TXT;
                r.status = ST_BCAST;
            end else if (code_in > CODE_LIMIT) begin
                r.chars  = INVAL_TXT;
                r.status = ST_INVALID;
            end else begin
                acc = 64'(code_in);
                i   = 0;
                if (code_in > EXT_FLOOR) begin
                    r.chars[0] = CH_HASH;
                    i          = 1;
                    acc        = 64'(code_in - EXT_OFFSET);
                end
                while (acc != 0 && i < NCHARS) begin
                    r.chars[i] = ALPHABET[int'(acc % RADIX)];
                    acc        = acc / RADIX;
                    i++;
                end
            end
        end
        return r;
    endfunction

    task automatic flag(string what, logic [63:0] want, logic [63:0] got);
        errs++;
        if (errs <= MAX_REPORTS)
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : watch
        codec_result_t want;
        codec_result_t got;
        int            k;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.chars  = m_tdata[SIDE_W-1:0];
                got.code   = m_tdata[TDATA_W-1:SIDE_W];
                got.status = bc_status_t'(m_tuser);
                if (awaited_results.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("%0t unexpected result, nothing pending: expected none, actual %h",
                                 $time, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    for (k = 0; k < NCHARS; k++) begin
                        if (got.chars[k] !== want.chars[k])
                            flag($sformatf("char %0d", k), 64'(want.chars[k]),
                                 64'(got.chars[k]));
                    end
                    if (got.code !== want.code)
                        flag("code", 64'(want.code), 64'(got.code));
                    if (got.status !== want.status)
                        flag("status", 64'(want.status), 64'(got.status));
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_codec(bc_op_t'(s_tuser[0]), s_tdata[SIDE_W-1:0],
                                     s_tdata[TDATA_W-1:SIDE_W]);
                awaited_results.push_back(want);
                if (bc_op_t'(s_tuser[0]) == OP_ENCODE) enc_cnt++;
                else dec_cnt++;
                if (want.status == ST_BCAST) bc_cnt++;
                if (want.status == ST_INVALID) inv_cnt++;
                if (want.status == ST_NORMAL && want.chars[0] == CH_HASH) ext_cnt++;
            end
            if (s_tvalid && !s_tready) held_cnt++;
        end
        fail_count      <= errs;
        pending_results <= awaited_results.size();
        n_encode        <= enc_cnt;
        n_decode        <= dec_cnt;
        n_bcast         <= bc_cnt;
        n_extended      <= ext_cnt;
        n_invalid       <= inv_cnt;
        n_held          <= held_cnt;
    end

endmodule

>>> tb/tb_base40_callsign_codec.sv
// testbench top for the base-40 callsign codec: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_base40_callsign_codec;
    import bc40_pkg::*;

    typedef logic [NCHARS-1:0][CHAR_W-1:0] char_row_t;

    // one input transaction before packing
    typedef struct packed {
        bc_op_t             op;
        char_row_t          chars;
        logic [CODE_W-1:0]  code;
    } codec_item_t;

    // receiver ready patterns
    typedef enum int {
        RX_FLOW,      // always ready
        RX_COIN,      // ready half the time, at random
        RX_SPARSE,    // ready a quarter of the time, at random
        RX_CADENCE    // fixed rhythm, ready two thirds of the time
    } rx_mode_t;

    localparam string ALPHABET     = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/.";
    localparam int    N_RANDOM     = 1400;
    localparam int    HOLD_CYCLES  = 120;     // long receiver hold-off, well past the pipe depth
    localparam int    STEADY_ITEMS = 200;     // back-to-back items offered during the hold-off
    localparam int    TAIL_CYCLES  = 60;      // tail wait after the drain, longer than the pipe is deep
    localparam int    LIMIT_CYCLES = 400000;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [TDATA_W-1:0]       s_tdata  = '0;
    logic [TUSER_IN_W-1:0]    s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [TDATA_W-1:0]       m_tdata;
    logic [TUSER_OUT_W-1:0]   m_tuser;

    int fail_count;
    int pending_results;
    int n_encode;
    int n_decode;
    int n_bcast;
    int n_extended;
    int n_invalid;
    int n_held;

    // sender idling state
    int burst_left  = 0;
    int no_gap_left = 0;
    bit hold_req    = 1'b0;
    int cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    base40_callsign_codec dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bc40_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .n_encode        (n_encode),
        .n_decode        (n_decode),
        .n_bcast         (n_bcast),
        .n_extended      (n_extended),
        .n_invalid       (n_invalid),
        .n_held          (n_held)
    );

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    function automatic logic [CODE_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[CODE_W-1:0];
    endfunction

    // uniform-ish value in [lo, hi], all 64-bit so the limits may be near 2^48
    function automatic logic [CODE_W-1:0] rand_between(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = lo + (v % (hi - lo + 1));
        return v[CODE_W-1:0];
    endfunction

    function automatic logic [63:0] pow40(int e);
        logic [63:0] v;
        int          k;
        v = 64'd1;
        for (k = 0; k < e; k++) v = v * 40;
        return v;
    endfunction

    // text literal to a character row, zero padded
    function automatic char_row_t text(string s);
        char_row_t v;
        int        k;
        v = '0;
        for (k = 0; k < s.len() && k < NCHARS; k++) v[k] = s[k];
        return v;
    endfunction

    function automatic codec_item_t enc_item(char_row_t chars);
        codec_item_t it;
        it.op    = OP_ENCODE;
        it.chars = chars;
        it.code  = rand48();    // ignored on encode, randomized anyway
        return it;
    endfunction

    function automatic codec_item_t dec_item(logic [CODE_W-1:0] code);
        codec_item_t it;
        int          k;
        it.op   = OP_DECODE;
        it.code = code;
        for (k = 0; k < NCHARS; k++) it.chars[k] = CHAR_W'($urandom_range(0, 255));
        return it;
    endfunction

    // one character of a callsign: mostly alphabet, some junk, lower case and stray '#'
    function automatic logic [CHAR_W-1:0] rand_sym();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return ALPHABET[$urandom_range(0, 39)];
        if (r < 90) return CHAR_W'($urandom_range(1, 255));
        if (r < 95) return CHAR_W'($urandom_range(8'h61, 8'h7A));
        return CH_HASH;
    endfunction

    function automatic codec_item_t rand_encode();
        char_row_t chars;
        int        len;
        int        kind;
        int        k;
        chars = '0;
        len   = $urandom_range(0, NCHARS);
        kind  = $urandom_range(0, 99);
        for (k = 0; k < NCHARS; k++) begin
            if (k < len)
                chars[k] = rand_sym();
            else if (k > len && $urandom_range(0, 1) == 1)
                chars[k] = CHAR_W'($urandom_range(0, 255));   // junk past the terminator
        end
        if (kind < 6) begin
            // broadcast, junk may follow the terminator
            chars[BCAST_LEN-1:0] = BCAST_TXT[BCAST_LEN*CHAR_W-1:0];
            chars[BCAST_LEN]     = CH_NUL;
        end else if (kind < 10) begin
            // near miss on broadcast: one character changed or one extra
            chars[BCAST_LEN-1:0] = BCAST_TXT[BCAST_LEN*CHAR_W-1:0];
            chars[BCAST_LEN]     = CH_NUL;
            chars[$urandom_range(0, BCAST_LEN)] = CHAR_W'($urandom_range(1, 255));
        end else if (kind < 22) begin
            chars[0] = CH_HASH;                              // extended range
        end else if (kind < 32 && len > 0) begin
            for (k = $urandom_range(0, len - 1); k < len; k++) chars[k] = CH_SPACE;
        end
        return enc_item(chars);
    endfunction

    function automatic codec_item_t rand_decode();
        logic [63:0] v;
        v = 64'(rand48());
        case ($urandom_range(0, 9))
            0:       v = 64'(rand48());
            1:       v = 64'(rand_between(0, pow40($urandom_range(1, 9)) - 1));
            2, 3, 4: v = 64'(rand_between(0, 64'(EXT_FLOOR)));
            5, 6:    v = 64'(rand_between(64'(EXT_OFFSET), 64'(CODE_LIMIT)));
            7:       v = 64'(rand_between(64'(CODE_LIMIT) + 1, 64'(CODE_BCAST) - 1));
            8: begin
                case ($urandom_range(0, 6))
                    0:       v = 64'd0;
                    1:       v = 64'(EXT_FLOOR);
                    2:       v = 64'(EXT_OFFSET);
                    3:       v = 64'(CODE_LIMIT);
                    4:       v = 64'(CODE_LIMIT) + 1;
                    5:       v = 64'(CODE_BCAST) - 1;
                    default: v = 64'(CODE_BCAST);
                endcase
            end
            default: begin
                // a single nonzero digit so the lower ones come out as inner spaces
                if ($urandom_range(0, 1) == 1)
                    v = 64'(EXT_OFFSET) + pow40($urandom_range(0, 7)) * $urandom_range(1, 39);
                else
                    v = pow40($urandom_range(0, 8)) * $urandom_range(1, 39);
            end
        endcase
        return dec_item(v[CODE_W-1:0]);
    endfunction

    // idle cycles before the next transaction: bursts of random length with
    // random gaps, some bursts glued together, none while the hold-off runs
    function automatic int idle_gap();
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(1, 8);
    endfunction

    // offer one transaction and wait until it is taken; valid stays high
    // when the next one follows with no gap
    task automatic send_item(codec_item_t it, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.code, it.chars};
        s_tuser  <= it.op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // ------------------------------------------------------------------
    // receiver: ready pattern of its own, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin : rx_pattern
        rx_mode_t mode;
        int       span;
        int       tick;
        bit       held;
        logic     rdy;
        held = 1'b0;
        tick = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span) begin
                if (hold_req && !held) begin
                    // stall the output so the pipe fills and s_tready drops
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    RX_FLOW:   rdy = 1'b1;
                    RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = (tick % 3 != 2);
                endcase
                tick++;
                m_tready <= rdy;
                @(posedge aclk);
            end
        end
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles, %0d results pending",
                     $time, cycle_count, pending_results);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        codec_item_t directed_q[$];
        char_row_t   row;
        int          k;

        // synchronous reset, released before the stimulus starts
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: broadcast, empty, all spaces, plain callsign, largest code
        directed_q.push_back(enc_item(text("@ALL")));
        directed_q.push_back(enc_item('0));
        directed_q.push_back(enc_item(text("         ")));
        directed_q.push_back(enc_item(text("W1AW")));
        directed_q.push_back(enc_item(text(".........")));
        // extended range: bare hash and the largest extended string
        directed_q.push_back(enc_item(text("#")));
        directed_q.push_back(enc_item(text("#........")));
        // lower case and other outside characters turn into spaces
        directed_q.push_back(enc_item(text("abc")));
        directed_q.push_back(enc_item(text("@ALLX")));
        directed_q.push_back(enc_item(text("AB#")));
        directed_q.push_back(enc_item('1));
        // characters after the first zero are ignored
        row    = text("A");
        row[2] = "B";
        directed_q.push_back(enc_item(row));
        // broadcast with junk after the terminator
        row = text("@ALL");
        for (k = BCAST_LEN + 1; k < NCHARS; k++) row[k] = 8'hFF;
        directed_q.push_back(enc_item(row));
        // inner and trailing spaces, digits and punctuation
        directed_q.push_back(enc_item(text("A B")));
        directed_q.push_back(enc_item(text("09-/.AZ  ")));
        directed_q.push_back(enc_item(text("#A  B")));
        // decode: zero, broadcast, range edges, single digits, inner zero digit
        directed_q.push_back(dec_item('0));
        directed_q.push_back(dec_item(CODE_BCAST));
        directed_q.push_back(dec_item(CODE_LIMIT));
        directed_q.push_back(dec_item(CODE_LIMIT + 48'd1));
        directed_q.push_back(dec_item(CODE_BCAST - 48'd1));
        directed_q.push_back(dec_item(EXT_FLOOR));
        directed_q.push_back(dec_item(EXT_OFFSET));
        directed_q.push_back(dec_item(48'd1));
        directed_q.push_back(dec_item(48'd40));

        foreach (directed_q[k]) send_item(directed_q[k], idle_gap());

        // random part opens with a steady stream against a stalled receiver
        hold_req    = 1'b1;
        no_gap_left = STEADY_ITEMS;
        for (k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 99) < 55)
                send_item(rand_encode(), idle_gap());
            else
                send_item(rand_decode(), idle_gap());
        end
        s_tvalid <= 1'b0;
        // let the checker count the last accepted transaction
        @(posedge aclk);

        // drain, then give the pipe time to show any stray result
        while (pending_results != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d encodes and %0d decodes: %0d broadcast, %0d extended, %0d invalid",
                 n_encode, n_decode, n_bcast, n_extended, n_invalid);
        $display("input was held off %0d cycles by output back-pressure", n_held);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending_results);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
